// ===== design/cbr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbr_pkg
// Shared widths, constants, codes and interface types of the cubic root
// bisection block.
// ---------------------------------------------------------------------------
package cbr_pkg;

   localparam int IN_W      = 36;
   localparam int IN1_W     = IN_W + 1;
   localparam int FRAC_BITS = 32;
   localparam int MAX_ITER  = 64;
   localparam int ITER_W    = 7;

   // product saturation to +-2^60
   localparam int SAT_W = 61;
   localparam int VAL_W = SAT_W + 1;
   localparam logic [SAT_W-1:0] SAT_LIM = SAT_W'(1) << (SAT_W - 1);

   // multiplier digit geometry
   localparam int DIG_W = 32;
   localparam int DIG_N = (VAL_W + DIG_W - 1) / DIG_W;
   localparam int AP_W  = DIG_N * DIG_W;
   localparam int PP_W  = DIG_W + IN_W;
   localparam int ACC_W = AP_W + IN_W;
   localparam int Q_W   = ACC_W - FRAC_BITS;
   localparam int Q1_W  = Q_W + 1;
   localparam int CNT_W = $clog2(DIG_N + 1);

   // cubic value width and the constant term 0.2
   localparam int F_W = 64;
   localparam logic [F_W-1:0] CUBIC_C = ((F_W'(1) << FRAC_BITS) + F_W'(2)) / F_W'(5);

   localparam logic [IN_W-1:0] TOL_RESET = IN_W'(429);

   typedef enum logic [1:0] {
      RSP_STEP      = 2'd0,
      RSP_ZERO      = 2'd1,
      RSP_NOBRACKET = 2'd2,
      RSP_LIMIT     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_POS,
      PH_NEG,
      PH_MID
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEL,
      S_SQ_GO,
      S_SQ_WAIT,
      S_CU_GO,
      S_CU_WAIT,
      S_FEVAL,
      S_DECIDE,
      S_CHECK,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic signed [IN_W-1:0] end_positive;
      logic signed [IN_W-1:0] end_negative;
   } req_type;

   typedef struct packed {
      logic [ITER_W-1:0]      iteration;
      logic signed [IN_W-1:0] midpoint;
      status_type             status;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic              load;
      logic              x_we;
      phase_type         x_sel;
      logic              mul_start;
      logic              mul_cube;
      logic              sq_we;
      logic              f_we;
      logic              sp_we;
      logic              upd;
      logic              out_we;
      logic [ITER_W-1:0] out_iter;
      status_type        out_status;
      logic              out_last;
      logic              out_nomid;
   } ctrl_cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic mul_done;
      logic not_bracketed;
      logic narrow;
      logic next_narrow;
      logic fzero;
      logic out_busy;
   } dp_status_type;

endpackage

// ===== design/cbr_mul.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbr_mul
// Iterative signed fixed-point multiplier: one 32-bit digit of the first
// operand per cycle, then floor scaling and saturation to +-2^60.
// ---------------------------------------------------------------------------
module cbr_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [cbr_pkg::VAL_W-1:0] a,
   input  logic signed [cbr_pkg::IN_W-1:0]  b,
   output logic                             busy,
   output logic                             done,
   output logic signed [cbr_pkg::VAL_W-1:0] res
);

   logic [cbr_pkg::AP_W-1:0]  ua_ff, ua_in;
   logic [cbr_pkg::IN_W-1:0]  ub_ff, ub_in;
   logic                      neg_ff, neg_in;
   logic [cbr_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [cbr_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      run_ff, run_in;
   logic                      fin_ff, fin_in;
   logic                      done_ff, done_in;
   logic signed [cbr_pkg::VAL_W-1:0] res_ff, res_in;

   logic [cbr_pkg::VAL_W-1:0] mag_a;
   logic [cbr_pkg::IN_W-1:0]  mag_b;
   logic [cbr_pkg::PP_W-1:0]  pp;
   logic [cbr_pkg::Q_W-1:0]   q;
   logic                      rem_nz;
   logic [cbr_pkg::Q1_W-1:0]  q_adj;
   logic [cbr_pkg::SAT_W-1:0] q_sat;
   logic signed [cbr_pkg::VAL_W-1:0] res_calc;

   assign mag_a = a[cbr_pkg::VAL_W-1] ? cbr_pkg::VAL_W'(-a) : cbr_pkg::VAL_W'(a);
   assign mag_b = b[cbr_pkg::IN_W-1] ? cbr_pkg::IN_W'(-b) : cbr_pkg::IN_W'(b);

   assign pp = cbr_pkg::PP_W'(ua_ff[cbr_pkg::AP_W-1 -: cbr_pkg::DIG_W])
             * cbr_pkg::PP_W'(ub_ff);

   // floor scaling, rounding toward minus infinity on negative products
   assign q      = acc_ff[cbr_pkg::ACC_W-1:cbr_pkg::FRAC_BITS];
   assign rem_nz = |acc_ff[cbr_pkg::FRAC_BITS-1:0];
   assign q_adj  = {1'b0, q} + cbr_pkg::Q1_W'(neg_ff & rem_nz);
   assign q_sat  = (q_adj > cbr_pkg::Q1_W'(cbr_pkg::SAT_LIM)) ? cbr_pkg::SAT_LIM
                                                             : q_adj[cbr_pkg::SAT_W-1:0];
   assign res_calc = neg_ff ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});

   always_comb begin
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      res_in  = fin_ff ? res_calc : res_ff;
      if (start) begin
         ua_in  = cbr_pkg::AP_W'(mag_a);
         ub_in  = mag_b;
         neg_in = a[cbr_pkg::VAL_W-1] ^ b[cbr_pkg::IN_W-1];
         acc_in = '0;
         cnt_in = cbr_pkg::CNT_W'(cbr_pkg::DIG_N);
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = (acc_ff << cbr_pkg::DIG_W) + cbr_pkg::ACC_W'(pp);
         ua_in  = ua_ff << cbr_pkg::DIG_W;
         cnt_in = cnt_ff - cbr_pkg::CNT_W'(1);
         if (cnt_ff == cbr_pkg::CNT_W'(1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign busy = run_ff | fin_ff;
   assign done = done_ff;
   assign res  = res_ff;

endmodule

// ===== design/cbr_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbr_datapath
// Bracket registers, midpoint, cubic evaluation around the shared
// multiplier, width tests, tolerance register and the result register.
// ---------------------------------------------------------------------------
module cbr_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  cbr_pkg::ctrl_cmd_type    cmd,
   output cbr_pkg::dp_status_type   status,
   input  cbr_pkg::req_type         req_data,
   input  logic                     csr_we,
   input  logic [cbr_pkg::IN_W-1:0] csr_wdata,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output cbr_pkg::rsp_type         rsp_data
);

   logic [cbr_pkg::IN_W-1:0]        tol_ff, tol_in;
   logic signed [cbr_pkg::IN_W-1:0] endp_ff, endp_in;
   logic signed [cbr_pkg::IN_W-1:0] endn_ff, endn_in;
   logic signed [cbr_pkg::IN_W-1:0] x_ff, x_in;
   logic signed [cbr_pkg::VAL_W-1:0] sq_ff, sq_in;
   logic fpos_ff, fpos_in, fzero_ff, fzero_in;
   logic sp_pos_ff, sp_pos_in, sp_zero_ff, sp_zero_in;
   logic rsp_valid_ff, rsp_valid_in;
   cbr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic signed [cbr_pkg::IN1_W-1:0] sum;
   logic signed [cbr_pkg::IN_W-1:0]  mid;
   logic signed [cbr_pkg::IN_W-1:0]  x_pick;
   logic signed [cbr_pkg::IN_W-1:0]  np, nn;
   logic signed [cbr_pkg::VAL_W-1:0] mul_a;
   logic signed [cbr_pkg::VAL_W-1:0] mul_res;
   logic                             mul_busy, mul_done;
   logic [cbr_pkg::F_W-1:0]          f_val;

   function automatic logic lt_tol(input logic signed [cbr_pkg::IN_W-1:0] p,
                                   input logic signed [cbr_pkg::IN_W-1:0] n,
                                   input logic [cbr_pkg::IN_W-1:0] t);
      logic signed [cbr_pkg::IN1_W-1:0] d;
      logic [cbr_pkg::IN1_W-1:0]        m;
      d = cbr_pkg::IN1_W'(p) - cbr_pkg::IN1_W'(n);
      m = d[cbr_pkg::IN_W] ? cbr_pkg::IN1_W'(-d) : cbr_pkg::IN1_W'(d);
      return m < {1'b0, t};
   endfunction

   // floor of the half sum
   assign sum = cbr_pkg::IN1_W'(endp_ff) + cbr_pkg::IN1_W'(endn_ff);
   assign mid = sum[cbr_pkg::IN_W:1];

   always_comb begin
      case (cmd.x_sel)
         cbr_pkg::PH_POS: x_pick = endp_ff;
         cbr_pkg::PH_NEG: x_pick = endn_ff;
         default:         x_pick = mid;
      endcase
   end

   assign mul_a = cmd.mul_cube ? mul_res : cbr_pkg::VAL_W'(x_ff);

   cbr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (x_ff),
      .busy  (mul_busy),
      .done  (mul_done),
      .res   (mul_res)
   );

   // cube - 3 sq + 2 x - 0.2, cube taken from the multiplier result
   assign f_val = cbr_pkg::F_W'(mul_res)
                - (cbr_pkg::F_W'(sq_ff) << 1) - cbr_pkg::F_W'(sq_ff)
                + (cbr_pkg::F_W'(x_ff) << 1) - cbr_pkg::CUBIC_C;

   assign np = fpos_ff ? x_ff : endp_ff;
   assign nn = fpos_ff ? endn_ff : x_ff;

   always_comb begin
      tol_in       = csr_we ? csr_wdata : tol_ff;
      endp_in      = endp_ff;
      endn_in      = endn_ff;
      x_in         = cmd.x_we ? x_pick : x_ff;
      sq_in        = cmd.sq_we ? mul_res : sq_ff;
      fpos_in      = fpos_ff;
      fzero_in     = fzero_ff;
      sp_pos_in    = cmd.sp_we ? fpos_ff : sp_pos_ff;
      sp_zero_in   = cmd.sp_we ? fzero_ff : sp_zero_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load) begin
         endp_in = req_data.end_positive;
         endn_in = req_data.end_negative;
      end else if (cmd.upd) begin
         endp_in = np;
         endn_in = nn;
      end
      if (cmd.f_we) begin
         fzero_in = (f_val == '0);
         fpos_in  = ~f_val[cbr_pkg::F_W-1] & (f_val != '0);
      end
      if (cmd.out_we) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.iteration = cmd.out_iter;
         rsp_data_in.midpoint  = cmd.out_nomid ? '0 : x_ff;
         rsp_data_in.status    = cmd.out_status;
         rsp_data_in.last      = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= cbr_pkg::TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      endp_ff     <= endp_in;
      endn_ff     <= endn_in;
      x_ff        <= x_in;
      sq_ff       <= sq_in;
      fpos_ff     <= fpos_in;
      fzero_ff    <= fzero_in;
      sp_pos_ff   <= sp_pos_in;
      sp_zero_ff  <= sp_zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.mul_busy      = mul_busy;
   assign status.mul_done      = mul_done;
   assign status.not_bracketed = ~sp_zero_ff & ~fzero_ff & (sp_pos_ff == fpos_ff);
   assign status.narrow        = lt_tol(endp_ff, endn_ff, tol_ff);
   assign status.next_narrow   = lt_tol(np, nn, tol_ff);
   assign status.fzero         = fzero_ff;
   assign status.out_busy      = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/cbr_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbr_ctrl
// Sequencer: evaluates the cubic at both ends, checks the bracket, then
// runs bisection steps and hands each result to the output register.
// ---------------------------------------------------------------------------
module cbr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cbr_pkg::dp_status_type status,
   output cbr_pkg::ctrl_cmd_type  cmd
);

   cbr_pkg::state_type  state_ff, state_in;
   cbr_pkg::phase_type  phase_ff, phase_in;
   logic [cbr_pkg::ITER_W-1:0] k_ff, k_in;
   cbr_pkg::status_type emit_status_ff, emit_status_in;
   logic emit_last_ff, emit_last_in;
   logic emit_nomid_ff, emit_nomid_in;
   logic [cbr_pkg::ITER_W-1:0] step_no;

   assign step_no = k_ff + cbr_pkg::ITER_W'(1);

   // next state
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      k_in           = k_ff;
      emit_status_in = emit_status_ff;
      emit_last_in   = emit_last_ff;
      emit_nomid_in  = emit_nomid_ff;
      unique case (state_ff)
         cbr_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = cbr_pkg::S_SEL;
               phase_in = cbr_pkg::PH_POS;
               k_in     = '0;
            end
         end
         cbr_pkg::S_SEL:   state_in = cbr_pkg::S_SQ_GO;
         cbr_pkg::S_SQ_GO: state_in = cbr_pkg::S_SQ_WAIT;
         cbr_pkg::S_SQ_WAIT: begin
            if (status.mul_done) state_in = cbr_pkg::S_CU_GO;
         end
         cbr_pkg::S_CU_GO: state_in = cbr_pkg::S_CU_WAIT;
         cbr_pkg::S_CU_WAIT: begin
            if (status.mul_done) state_in = cbr_pkg::S_FEVAL;
         end
         cbr_pkg::S_FEVAL: state_in = cbr_pkg::S_DECIDE;
         cbr_pkg::S_DECIDE: begin
            unique case (phase_ff)
               cbr_pkg::PH_POS: begin
                  phase_in = cbr_pkg::PH_NEG;
                  state_in = cbr_pkg::S_SEL;
               end
               cbr_pkg::PH_NEG: begin
                  if (status.not_bracketed) begin
                     emit_status_in = cbr_pkg::RSP_NOBRACKET;
                     emit_last_in   = 1'b1;
                     emit_nomid_in  = 1'b1;
                     state_in       = cbr_pkg::S_EMIT;
                  end else begin
                     state_in = cbr_pkg::S_CHECK;
                  end
               end
               default: begin
                  emit_nomid_in = 1'b0;
                  state_in      = cbr_pkg::S_EMIT;
                  if (status.fzero) begin
                     emit_status_in = cbr_pkg::RSP_ZERO;
                     emit_last_in   = 1'b1;
                  end else if (status.next_narrow) begin
                     emit_status_in = cbr_pkg::RSP_STEP;
                     emit_last_in   = 1'b1;
                  end else if (step_no >= cbr_pkg::ITER_W'(cbr_pkg::MAX_ITER)) begin
                     emit_status_in = cbr_pkg::RSP_LIMIT;
                     emit_last_in   = 1'b1;
                  end else begin
                     emit_status_in = cbr_pkg::RSP_STEP;
                     emit_last_in   = 1'b0;
                  end
               end
            endcase
         end
         cbr_pkg::S_CHECK: begin
            if (status.narrow) begin
               state_in = cbr_pkg::S_IDLE;
            end else begin
               phase_in = cbr_pkg::PH_MID;
               state_in = cbr_pkg::S_SEL;
            end
         end
         cbr_pkg::S_EMIT: begin
            if (!status.out_busy) begin
               if (emit_last_ff) begin
                  state_in = cbr_pkg::S_IDLE;
               end else begin
                  k_in     = step_no;
                  state_in = cbr_pkg::S_SEL;
               end
            end
         end
         default: state_in = cbr_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.x_sel      = phase_ff;
      cmd.out_iter   = emit_nomid_ff ? '0 : step_no;
      cmd.out_status = emit_status_ff;
      cmd.out_last   = emit_last_ff;
      cmd.out_nomid  = emit_nomid_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         cbr_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         cbr_pkg::S_SEL:   cmd.x_we = 1'b1;
         cbr_pkg::S_SQ_GO: cmd.mul_start = 1'b1;
         cbr_pkg::S_CU_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_cube  = 1'b1;
            cmd.sq_we     = 1'b1;
         end
         cbr_pkg::S_FEVAL: cmd.f_we = 1'b1;
         cbr_pkg::S_DECIDE: begin
            cmd.sp_we = (phase_ff == cbr_pkg::PH_POS);
            cmd.upd   = (phase_ff == cbr_pkg::PH_MID) & ~status.fzero;
         end
         cbr_pkg::S_EMIT: cmd.out_we = ~status.out_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbr_pkg::S_IDLE;
         phase_ff <= cbr_pkg::PH_POS;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
      end
      emit_status_ff <= emit_status_in;
      emit_last_ff   <= emit_last_in;
      emit_nomid_ff  <= emit_nomid_in;
   end

`ifndef NO_ASSERTIONS
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !status.mul_busy)
      else $error("multiplier started while busy");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_we |-> !status.out_busy)
      else $error("result register overwritten");

   a_iter_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.out_we |-> cmd.out_iter <= cbr_pkg::ITER_W'(cbr_pkg::MAX_ITER))
      else $error("iteration beyond cap");

   a_nobracket: assert property (@(posedge clock) disable iff (reset)
      cmd.out_we && cmd.out_status == cbr_pkg::RSP_NOBRACKET
      |-> cmd.out_last && cmd.out_iter == '0)
      else $error("bad not-bracketed result");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.mul_busy)
      else $error("multiplier active while idle");
`endif

endmodule

// ===== design/cubic_root_bisection.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cubic_root_bisection
// Bisection root finder for f(x) = x^3 - 3x^2 + 2x - 0.2 in signed Q4.32.
//
// req channel: one item is a bracket (end_positive, end_negative); it is
// taken only while the block is idle. rsp channel: one item per bisection
// step (iteration, midpoint, status, last), or a single not-bracketed item;
// a bracket already narrower than the tolerance gives no item at all.
// csr_we/csr_wdata write the stop tolerance, reset value 429.
// Each cubic evaluation makes two passes through the shared multiplier
// (two 32-bit digits each, plus scaling). Both ends are evaluated first,
// then each step evaluates the cubic once, at the midpoint.
// Reset is synchronous: it returns the sequencer to idle, drops rsp_valid
// and restores the tolerance. If the receiver stalls, the finished result
// waits in the output register while the next step is computed; the
// block then holds until that result is taken.
// ---------------------------------------------------------------------------
module cubic_root_bisection (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cbr_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cbr_pkg::rsp_type         rsp_data,
   input  logic                     csr_we,
   input  logic [cbr_pkg::IN_W-1:0] csr_wdata
);

   cbr_pkg::ctrl_cmd_type  cmd;
   cbr_pkg::dp_status_type status;

   cbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
